@@ rtl/bss_pkg.sv @@
// Shared types, constants and helpers of the banked step sequencer.
// No dependencies; every other file refers to it by scoped names.
package bss_pkg;

    localparam int NUM_STEPS = 8;
    localparam int STEP_W    = 3;
    localparam int WORD_W    = 8;
    localparam int SEL_W     = 2;
    localparam int BANK_W    = 2;
    localparam int NIB_W     = 4;
    localparam int ROW_W     = 8;

    // Item opcodes
    localparam logic OP_PINS  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Control from the top level to each step lane
    typedef struct packed {
        logic              frame;  // current item is a frame
        logic              take;   // item accepted this cycle
        logic [BANK_W-1:0] bank;   // bank held before the frame
    } t_lane_ctl;

    // Control from the top level to the merge stage
    typedef struct packed {
        logic              relatch;
        logic [STEP_W-1:0] index;
        logic [STEP_W-1:0] held_addr;
        logic [WORD_W-1:0] held_mux;
        logic [BANK_W-1:0] bank;
    } t_merge_ctl;

    typedef struct packed {
        logic [STEP_W-1:0] address_out;
        logic [WORD_W-1:0] mux_out;
        logic              outputs_updated;
        logic [BANK_W-1:0] bank_now;
        logic              display_dirty;
    } t_result;

    // Position of the highest set bit of a nibble (0 when empty)
    function automatic logic [SEL_W-1:0] top_bit(input logic [NIB_W-1:0] v);
        logic [SEL_W-1:0] r;
        if (v[3]) begin
            r = 2'd3;
        end else if (v[2]) begin
            r = 2'd2;
        end else if (v[1]) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

@@ rtl/bss_if.sv @@
// Handshake channels of the banked step sequencer: input items and results.
// Depends on bss_pkg for field widths.
interface bss_item_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic                        trig_level;
    logic                        reset_level;
    logic                        sync_switch;
    logic [bss_pkg::ROW_W-1:0]   row_zero_raw;
    logic [bss_pkg::ROW_W-1:0]   row_one_raw;
    logic [bss_pkg::ROW_W-1:0]   row_two_raw;
    logic [bss_pkg::ROW_W-1:0]   row_three_raw;
    logic [bss_pkg::ROW_W-1:0]   row_bank_raw;

    modport source (
        output valid, op, trig_level, reset_level, sync_switch,
               row_zero_raw, row_one_raw, row_two_raw, row_three_raw, row_bank_raw,
        input  ready
    );
    modport sink (
        input  valid, op, trig_level, reset_level, sync_switch,
               row_zero_raw, row_one_raw, row_two_raw, row_three_raw, row_bank_raw,
        output ready
    );
endinterface

interface bss_result_if;
    logic                        valid;
    logic                        ready;
    logic [bss_pkg::STEP_W-1:0]  address_out;
    logic [bss_pkg::WORD_W-1:0]  mux_out;
    logic                        outputs_updated;
    logic [bss_pkg::BANK_W-1:0]  bank_now;
    logic                        display_dirty;

    modport source (
        output valid, address_out, mux_out, outputs_updated, bank_now, display_dirty,
        input  ready
    );
    modport sink (
        input  valid, address_out, mux_out, outputs_updated, bank_now, display_dirty,
        output ready
    );
endinterface

@@ rtl/bss_lane.sv @@
// One step lane: holds the step word and the pressed state of its key nibble.
// Depends on bss_pkg.
module bss_lane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bss_pkg::t_lane_ctl         i_ctl,
    input  logic [bss_pkg::NIB_W-1:0]  i_raw,
    output logic [bss_pkg::WORD_W-1:0] o_word_next
);
    logic [bss_pkg::WORD_W-1:0] r_word;
    logic [bss_pkg::NIB_W-1:0]  r_prev;
    logic [bss_pkg::WORD_W-1:0] n_word;
    logic [bss_pkg::NIB_W-1:0]  pressed;
    logic [bss_pkg::NIB_W-1:0]  fresh;
    logic [bss_pkg::STEP_W-1:0] shift;
    logic [bss_pkg::WORD_W-1:0] mask;
    logic [bss_pkg::WORD_W-1:0] field;

    assign pressed = ~i_raw;
    assign fresh   = pressed & ~r_prev;
    assign shift   = {i_ctl.bank, 1'b0};
    assign mask    = bss_pkg::WORD_W'(2'b11) << shift;
    assign field   = bss_pkg::WORD_W'(bss_pkg::top_bit(fresh)) << shift;

    // highest fresh key of the nibble wins
    always_comb begin
        n_word = r_word;
        if (i_ctl.frame && (|fresh)) begin
            n_word = (r_word & ~mask) | field;
        end
    end

    assign o_word_next = n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_prev <= '0;
        end else if (i_ctl.take && i_ctl.frame) begin
            r_word <= n_word;
            r_prev <= pressed;
        end
    end
endmodule

@@ rtl/bss_merge.sv @@
// Merge stage: picks the word of the output step from the lanes and forms the result.
// Depends on bss_pkg.
module bss_merge (
    input  logic [bss_pkg::WORD_W-1:0] i_words [bss_pkg::NUM_STEPS],
    input  bss_pkg::t_merge_ctl        i_ctl,
    output bss_pkg::t_result           o_result
);
    logic [bss_pkg::WORD_W-1:0] sel_word;

    assign sel_word = i_words[i_ctl.index];

    always_comb begin
        o_result.address_out     = i_ctl.relatch ? i_ctl.index : i_ctl.held_addr;
        o_result.mux_out         = i_ctl.relatch ? sel_word : i_ctl.held_mux;
        o_result.outputs_updated = i_ctl.relatch;
        o_result.bank_now        = i_ctl.bank;
        // every relatch redraws; a frame always relatches
        o_result.display_dirty   = i_ctl.relatch;
    end
endmodule

@@ rtl/banked_step_sequencer.sv @@
// Banked step sequencer: usage overview.
// Channels: i_item (sink) carries pin samples (op 0) and frames with button
//   rows (op 1); o_result (source) gives one result transaction per item.
// Handshake: a transaction moves at a rising edge with valid and ready high.
// Result: each item's result is registered in the output register or skid.
// Throughput: one item per cycle unless the receiver stalls. The eight step
//   lanes edit their words in parallel and the merge stage selects the
//   output word in the same cycle, so no loop holds the next item back.
// Stall: an output register plus a one-entry skid buffer; while the receiver
//   stalls, one more item is taken into the skid, after which i_item.ready
//   drops until the output register drains.
// Reset (i_rst_n, synchronous, active low): step index, all step words,
//   button and pin history, bank, sync mode and latched outputs go to zero;
//   both result slots are emptied. No clearing pass is needed.
// Sync mode set by a frame holds the outputs until the next frame; pin edges
//   still move the step index.
// Files: bss_pkg, bss_if, bss_lane, bss_merge.
module banked_step_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bss_item_if.sink      i_item,
    bss_result_if.source  o_result
);
    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [bss_pkg::STEP_W-1:0] r_step_index;
    logic [1:0]                 r_prev_pins;   // bit 0 trigger, bit 1 reset
    logic [bss_pkg::BANK_W-1:0] r_bank;
    logic [bss_pkg::NIB_W-1:0]  r_prev_bank;   // bank row keys 4-7 only
    logic                       r_sync;
    logic [bss_pkg::STEP_W-1:0] r_lat_addr;
    logic [bss_pkg::WORD_W-1:0] r_lat_mux;

    // Output register and skid buffer
    logic                       r_out_v;
    bss_pkg::t_result           r_out;
    logic                       r_skid_v;
    bss_pkg::t_result           r_skid;

    logic                       accept;
    logic                       is_frame;
    logic [1:0]                 pins_now;
    logic [1:0]                 rising;
    logic [bss_pkg::STEP_W-1:0] n_step_index;
    logic [bss_pkg::BANK_W-1:0] n_bank;
    logic [bss_pkg::NIB_W-1:0]  bank_pressed;
    logic [bss_pkg::NIB_W-1:0]  bank_fresh;
    logic                       relatch;
    logic                       out_free;

    bss_pkg::t_lane_ctl         lane_ctl;
    bss_pkg::t_merge_ctl        merge_ctl;
    bss_pkg::t_result           res;
    logic [bss_pkg::WORD_W-1:0] words_next [bss_pkg::NUM_STEPS];
    logic [bss_pkg::ROW_W-1:0]  rows [bss_pkg::NUM_STEPS/2];

    assign i_item.ready = !r_skid_v;
    assign accept       = i_item.valid && i_item.ready;
    assign is_frame     = (i_item.op == bss_pkg::OP_FRAME);
    assign out_free     = !r_out_v || o_result.ready;

    // ------------------------------------------------------------------
    // Pin edges: trigger first, then reset wins
    // ------------------------------------------------------------------
    assign pins_now = {i_item.reset_level, i_item.trig_level};
    assign rising   = pins_now & ~r_prev_pins;

    always_comb begin
        n_step_index = r_step_index;
        if (!is_frame) begin
            if (rising[1]) begin
                n_step_index = '0;
            end else if (rising[0]) begin
                n_step_index = r_step_index + 3'd1;
            end
        end
    end

    // frames always relatch; pin edges only outside sync mode
    assign relatch = is_frame || ((|rising) && !r_sync);

    // ------------------------------------------------------------------
    // Bank row: fresh keys 4-7, highest wins; steps use the old bank
    // ------------------------------------------------------------------
    assign bank_pressed = ~i_item.row_bank_raw[7:4];
    assign bank_fresh   = bank_pressed & ~r_prev_bank;
    assign n_bank       = (is_frame && (|bank_fresh)) ? bss_pkg::top_bit(bank_fresh)
                                                      : r_bank;

    // ------------------------------------------------------------------
    // Step lanes: two per button row
    // ------------------------------------------------------------------
    assign lane_ctl.frame = is_frame;
    assign lane_ctl.take  = accept;
    assign lane_ctl.bank  = r_bank;

    assign rows[0] = i_item.row_zero_raw;
    assign rows[1] = i_item.row_one_raw;
    assign rows[2] = i_item.row_two_raw;
    assign rows[3] = i_item.row_three_raw;

    for (genvar g = 0; g < bss_pkg::NUM_STEPS; g++) begin : g_lane
        bss_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl),
            .i_raw       (rows[g/2][(g%2)*bss_pkg::NIB_W +: bss_pkg::NIB_W]),
            .o_word_next (words_next[g])
        );
    end

    // ------------------------------------------------------------------
    // Merge: select the output step's word, build the result
    // ------------------------------------------------------------------
    assign merge_ctl.relatch   = relatch;
    assign merge_ctl.index     = n_step_index;
    assign merge_ctl.held_addr = r_lat_addr;
    assign merge_ctl.held_mux  = r_lat_mux;
    assign merge_ctl.bank      = n_bank;

    bss_merge u_merge (
        .i_words  (words_next),
        .i_ctl    (merge_ctl),
        .o_result (res)
    );

    // ------------------------------------------------------------------
    // State update on each accepted transaction
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_index <= '0;
            r_prev_pins  <= '0;
            r_bank       <= '0;
            r_prev_bank  <= '0;
            r_sync       <= 1'b0;
            r_lat_addr   <= '0;
            r_lat_mux    <= '0;
        end else if (accept) begin
            r_step_index <= n_step_index;
            r_bank       <= n_bank;
            r_lat_addr   <= res.address_out;
            r_lat_mux    <= res.mux_out;
            if (is_frame) begin
                r_sync      <= i_item.sync_switch;
                r_prev_bank <= bank_pressed;
            end else begin
                r_prev_pins <= pins_now;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid buffer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            // skid full means no accept this cycle
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= accept;
            end
        end else if (accept) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_result.valid           = r_out_v;
    assign o_result.address_out     = r_out.address_out;
    assign o_result.mux_out         = r_out.mux_out;
    assign o_result.outputs_updated = r_out.outputs_updated;
    assign o_result.bank_now        = r_out.bank_now;
    assign o_result.display_dirty   = r_out.display_dirty;

`ifndef SYNTH
    // skid only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid buffer valid with empty output register");

    // sync mode freezes the latched address across pin samples
    a_sync_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_frame && r_sync) |=> $stable(r_lat_addr))
        else $error("latched address moved in sync mode");

    // a frame relatches the unchanged step index
    a_frame_relatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_frame) |=> (r_lat_addr == $past(r_step_index)))
        else $error("frame did not relatch current step");

    // a rising reset pin always returns the index to step 0
    a_reset_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_frame && rising[1]) |=> (r_step_index == '0))
        else $error("reset edge did not clear step index");
`endif
endmodule
